// ----- rtl/rsnh_pkg.sv -----
// Shared widths, register indexes and types for the ray segment nearest-hit block.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package rsnh_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;       // coordinate difference
    localparam int ACC_W      = 2 * DIFF_W + 1;       // signed cross product a*b - c*d
    localparam int NUM_W      = ACC_W - 1;            // normalized den / nt magnitude
    localparam int REM_W      = NUM_W + 1;            // divider remainder with headroom
    localparam int MAG_W      = COORD_BITS + 2;       // scale operand, one bit per step
    localparam int DSQ_W      = 2 * COORD_BITS + 2;   // squared distance
    localparam int CNT_W      = $clog2(MAG_W);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
    } ser_ctl_t;

    function automatic logic signed [DIFF_W-1:0] ext_coord(input logic signed [COORD_BITS-1:0] v);
        return {v[COORD_BITS-1], v};
    endfunction

endpackage

// ----- rtl/rsnh_cross.sv -----
// Bit-serial signed cross product a*b - c*d, multiplier bits taken MSB first.
// Depends on rsnh_pkg.
module rsnh_cross (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rsnh_pkg::ser_ctl_t                   ctl,
    input  logic signed [rsnh_pkg::DIFF_W-1:0]   mcand_a,
    input  logic signed [rsnh_pkg::DIFF_W-1:0]   mplier_b,
    input  logic signed [rsnh_pkg::DIFF_W-1:0]   mcand_c,
    input  logic signed [rsnh_pkg::DIFF_W-1:0]   mplier_d,
    output logic signed [rsnh_pkg::ACC_W-1:0]    result
);

    logic signed [rsnh_pkg::ACC_W-1:0]  acc_reg;
    logic signed [rsnh_pkg::ACC_W-1:0]  acc_next;
    logic signed [rsnh_pkg::DIFF_W-1:0] a_reg;
    logic signed [rsnh_pkg::DIFF_W-1:0] c_reg;
    logic        [rsnh_pkg::DIFF_W-1:0] b_sh_reg;
    logic        [rsnh_pkg::DIFF_W-1:0] d_sh_reg;
    logic                               first_reg;

    logic signed [rsnh_pkg::ACC_W-1:0]  term_a;
    logic signed [rsnh_pkg::ACC_W-1:0]  term_c;
    logic signed [rsnh_pkg::ACC_W-1:0]  acc_sh;

    always_comb
    begin
        term_a = b_sh_reg[rsnh_pkg::DIFF_W-1]
               ? {{(rsnh_pkg::ACC_W-rsnh_pkg::DIFF_W){a_reg[rsnh_pkg::DIFF_W-1]}}, a_reg}
               : '0;
        term_c = d_sh_reg[rsnh_pkg::DIFF_W-1]
               ? {{(rsnh_pkg::ACC_W-rsnh_pkg::DIFF_W){c_reg[rsnh_pkg::DIFF_W-1]}}, c_reg}
               : '0;
        acc_sh = {acc_reg[rsnh_pkg::ACC_W-2:0], 1'b0};
        // sign bit of a two's complement multiplier carries negative weight
        if (first_reg)
        begin
            acc_next = acc_sh + term_c - term_a;
        end
        else
        begin
            acc_next = acc_sh + term_a - term_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.step)
        begin
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            acc_reg  <= '0;
            a_reg    <= mcand_a;
            c_reg    <= mcand_c;
            b_sh_reg <= mplier_b;
            d_sh_reg <= mplier_d;
        end
        else if (ctl.step)
        begin
            acc_reg  <= acc_next;
            b_sh_reg <= {b_sh_reg[rsnh_pkg::DIFF_W-2:0], 1'b0};
            d_sh_reg <= {d_sh_reg[rsnh_pkg::DIFF_W-2:0], 1'b0};
        end
    end

    assign result = acc_reg;

endmodule

// ----- rtl/rsnh_div.sv -----
// Bit-serial trunc(num*mag/den) for 0 < num < den, one bit of mag per step.
// Depends on rsnh_pkg.
module rsnh_div (
    input  logic                           clk,
    input  rsnh_pkg::ser_ctl_t             ctl,
    input  logic [rsnh_pkg::NUM_W-1:0]     num,
    input  logic [rsnh_pkg::NUM_W-1:0]     den,
    input  logic [rsnh_pkg::MAG_W-1:0]     mag,
    output logic [rsnh_pkg::MAG_W-1:0]     quot
);

    logic [rsnh_pkg::REM_W-1:0] rem_reg;
    logic [rsnh_pkg::REM_W-1:0] rem_next;
    logic [rsnh_pkg::MAG_W-1:0] quot_reg;
    logic [rsnh_pkg::MAG_W-1:0] quot_next;
    logic [rsnh_pkg::MAG_W-1:0] mag_sh_reg;
    logic [rsnh_pkg::NUM_W-1:0] num_reg;
    logic [rsnh_pkg::NUM_W-1:0] den_reg;

    logic [rsnh_pkg::REM_W-1:0] den_ext;
    logic [rsnh_pkg::REM_W-1:0] num_ext;
    logic [rsnh_pkg::REM_W-1:0] r_dbl;
    logic [rsnh_pkg::REM_W-1:0] r_red;
    logic [rsnh_pkg::REM_W-1:0] r_add;
    logic                       carry_dbl;
    logic                       carry_add;
    logic                       mbit;

    always_comb
    begin
        den_ext   = {1'b0, den_reg};
        num_ext   = {1'b0, num_reg};
        mbit      = mag_sh_reg[rsnh_pkg::MAG_W-1];
        // remainder stays below den, so each half-step needs one subtract at most
        r_dbl     = {rem_reg[rsnh_pkg::REM_W-2:0], 1'b0};
        carry_dbl = (r_dbl >= den_ext);
        r_red     = carry_dbl ? (r_dbl - den_ext) : r_dbl;
        r_add     = r_red + num_ext;
        carry_add = mbit && (r_add >= den_ext);
        if (carry_add)
        begin
            rem_next = r_add - den_ext;
        end
        else if (mbit)
        begin
            rem_next = r_add;
        end
        else
        begin
            rem_next = r_red;
        end
        quot_next = {quot_reg[rsnh_pkg::MAG_W-2:0], carry_dbl}
                  + {{(rsnh_pkg::MAG_W-1){1'b0}}, carry_add};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg    <= '0;
            quot_reg   <= '0;
            mag_sh_reg <= mag;
            num_reg    <= num;
            den_reg    <= den;
        end
        else if (ctl.step)
        begin
            rem_reg    <= rem_next;
            quot_reg   <= quot_next;
            mag_sh_reg <= {mag_sh_reg[rsnh_pkg::MAG_W-2:0], 1'b0};
        end
    end

    assign quot = quot_reg;

endmodule

// ----- rtl/ray_segment_nearest_hit.sv -----
// Top level: sequencer, light registers, hit point, distance compare and output beat.
// Depends on rsnh_pkg, rsnh_cross and rsnh_div.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | ray_end_x/y, wall_ax/ay/bx/by, last_wall
//  out     | out_valid/out_stall| hit_found, end_x, end_y
//  cfg     | cfg_write_en       | cfg_index, cfg_data (light_x, light_y)
//
// Every wall runs the three cross products, one multiplier bit per cycle; a hit then
// adds the two serial scale/divide units and the squared-distance steps.
// One wall at a time; in_stall is high from accept until the wall is finished.
// Reset clears the light position and the held hit. The last wall waits in the
// finish step only while the output register holds a beat not yet taken.
module ray_segment_nearest_hit (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [rsnh_pkg::COORD_BITS-1:0]    ray_end_x,
    input  logic signed [rsnh_pkg::COORD_BITS-1:0]    ray_end_y,
    input  logic signed [rsnh_pkg::COORD_BITS-1:0]    wall_ax,
    input  logic signed [rsnh_pkg::COORD_BITS-1:0]    wall_ay,
    input  logic signed [rsnh_pkg::COORD_BITS-1:0]    wall_bx,
    input  logic signed [rsnh_pkg::COORD_BITS-1:0]    wall_by,
    input  logic                                      last_wall,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic                                      hit_found,
    output logic signed [rsnh_pkg::COORD_BITS-1:0]    end_x,
    output logic signed [rsnh_pkg::COORD_BITS-1:0]    end_y,
    input  logic                                      cfg_write_en,
    input  logic        [rsnh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic        [rsnh_pkg::COORD_BITS-1:0]    cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_NORM = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_PT   = 9'b000010000,
        S_SQX  = 9'b000100000,
        S_SQY  = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [rsnh_pkg::CNT_W-1:0]               cnt_reg;
    logic                                     out_valid_reg;
    logic                                     have_hit_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   light_x_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   light_y_reg;

    logic signed [rsnh_pkg::COORD_BITS-1:0]   ex_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   ey_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   ax_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   ay_reg;
    logic signed [rsnh_pkg::DIFF_W-1:0]       dbx_reg;
    logic signed [rsnh_pkg::DIFF_W-1:0]       dby_reg;
    logic                                     last_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   px_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   py_reg;
    logic        [rsnh_pkg::DSQ_W-1:0]        sqx_reg;
    logic        [rsnh_pkg::DSQ_W-1:0]        sqy_reg;
    logic        [rsnh_pkg::DSQ_W-1:0]        best_dist_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   best_px_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   best_py_reg;
    logic                                     hit_found_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   end_x_reg;
    logic signed [rsnh_pkg::COORD_BITS-1:0]   end_y_reg;

    logic                                     in_accept;
    logic                                     fin_load;
    rsnh_pkg::ser_ctl_t                       cross_ctl;
    rsnh_pkg::ser_ctl_t                       div_ctl;

    logic signed [rsnh_pkg::DIFF_W-1:0]       d_xab;
    logic signed [rsnh_pkg::DIFF_W-1:0]       d_yab;
    logic signed [rsnh_pkg::DIFF_W-1:0]       d_xal;
    logic signed [rsnh_pkg::DIFF_W-1:0]       d_yal;
    logic signed [rsnh_pkg::DIFF_W-1:0]       d_xle;
    logic signed [rsnh_pkg::DIFF_W-1:0]       d_yle;

    logic signed [rsnh_pkg::ACC_W-1:0]        den_raw;
    logic signed [rsnh_pkg::ACC_W-1:0]        nt_raw;
    logic signed [rsnh_pkg::ACC_W-1:0]        nu_raw;
    logic signed [rsnh_pkg::ACC_W-1:0]        den_n;
    logic signed [rsnh_pkg::ACC_W-1:0]        nt_n;
    logic signed [rsnh_pkg::ACC_W-1:0]        nu_n;
    logic                                     wall_hit;

    logic        [rsnh_pkg::DIFF_W-1:0]       abs_dbx;
    logic        [rsnh_pkg::DIFF_W-1:0]       abs_dby;
    logic        [rsnh_pkg::MAG_W-1:0]        qx;
    logic        [rsnh_pkg::MAG_W-1:0]        qy;
    logic signed [rsnh_pkg::MAG_W:0]          qx_s;
    logic signed [rsnh_pkg::MAG_W:0]          qy_s;
    logic signed [rsnh_pkg::MAG_W:0]          px_full;
    logic signed [rsnh_pkg::MAG_W:0]          py_full;
    logic signed [rsnh_pkg::DIFF_W-1:0]       dx;
    logic signed [rsnh_pkg::DIFF_W-1:0]       dy;
    logic signed [2*rsnh_pkg::DIFF_W-1:0]     sq_x;
    logic signed [2*rsnh_pkg::DIFF_W-1:0]     sq_y;
    logic        [rsnh_pkg::DSQ_W-1:0]        dsq;
    logic                                     take_best;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign fin_load  = (state_reg == S_FIN) && last_reg && (!out_valid_reg || !out_stall);

    // operand differences, taken from the input beat and the light registers
    always_comb
    begin
        d_xab = rsnh_pkg::ext_coord(wall_ax) - rsnh_pkg::ext_coord(wall_bx);
        d_yab = rsnh_pkg::ext_coord(wall_ay) - rsnh_pkg::ext_coord(wall_by);
        d_xal = rsnh_pkg::ext_coord(wall_ax) - rsnh_pkg::ext_coord(light_x_reg);
        d_yal = rsnh_pkg::ext_coord(wall_ay) - rsnh_pkg::ext_coord(light_y_reg);
        d_xle = rsnh_pkg::ext_coord(light_x_reg) - rsnh_pkg::ext_coord(ray_end_x);
        d_yle = rsnh_pkg::ext_coord(light_y_reg) - rsnh_pkg::ext_coord(ray_end_y);
    end

    assign cross_ctl.load = in_accept;
    assign cross_ctl.step = (state_reg == S_MUL);

    rsnh_cross u_den (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cross_ctl),
        .mcand_a  (d_xab),
        .mplier_b (d_yle),
        .mcand_c  (d_yab),
        .mplier_d (d_xle),
        .result   (den_raw)
    );

    rsnh_cross u_nt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cross_ctl),
        .mcand_a  (d_xal),
        .mplier_b (d_yle),
        .mcand_c  (d_yal),
        .mplier_d (d_xle),
        .result   (nt_raw)
    );

    rsnh_cross u_nu (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cross_ctl),
        .mcand_a  (d_xal),
        .mplier_b (d_yab),
        .mcand_c  (d_yal),
        .mplier_d (d_xab),
        .result   (nu_raw)
    );

    // flip all three together so the denominator is not negative
    always_comb
    begin
        if (den_raw[rsnh_pkg::ACC_W-1])
        begin
            den_n = -den_raw;
            nt_n  = -nt_raw;
            nu_n  = -nu_raw;
        end
        else
        begin
            den_n = den_raw;
            nt_n  = nt_raw;
            nu_n  = nu_raw;
        end
        wall_hit = (den_n != '0) && (nt_n > 0) && (nt_n < den_n) && (nu_n > 0);
        abs_dbx  = dbx_reg[rsnh_pkg::DIFF_W-1] ? $unsigned(-dbx_reg) : $unsigned(dbx_reg);
        abs_dby  = dby_reg[rsnh_pkg::DIFF_W-1] ? $unsigned(-dby_reg) : $unsigned(dby_reg);
    end

    assign div_ctl.load = (state_reg == S_NORM) && wall_hit;
    assign div_ctl.step = (state_reg == S_DIV);

    rsnh_div u_div_x (
        .clk  (clk),
        .ctl  (div_ctl),
        .num  (nt_n[rsnh_pkg::NUM_W-1:0]),
        .den  (den_n[rsnh_pkg::NUM_W-1:0]),
        .mag  ({{(rsnh_pkg::MAG_W-rsnh_pkg::DIFF_W){1'b0}}, abs_dbx}),
        .quot (qx)
    );

    rsnh_div u_div_y (
        .clk  (clk),
        .ctl  (div_ctl),
        .num  (nt_n[rsnh_pkg::NUM_W-1:0]),
        .den  (den_n[rsnh_pkg::NUM_W-1:0]),
        .mag  ({{(rsnh_pkg::MAG_W-rsnh_pkg::DIFF_W){1'b0}}, abs_dby}),
        .quot (qy)
    );

    // hit point, distance terms and the running-minimum compare
    always_comb
    begin
        qx_s = dbx_reg[rsnh_pkg::DIFF_W-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        qy_s = dby_reg[rsnh_pkg::DIFF_W-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        px_full = {{(rsnh_pkg::MAG_W+1-rsnh_pkg::COORD_BITS){ax_reg[rsnh_pkg::COORD_BITS-1]}},
                   ax_reg} + qx_s;
        py_full = {{(rsnh_pkg::MAG_W+1-rsnh_pkg::COORD_BITS){ay_reg[rsnh_pkg::COORD_BITS-1]}},
                   ay_reg} + qy_s;
        dx = rsnh_pkg::ext_coord(px_reg) - rsnh_pkg::ext_coord(light_x_reg);
        dy = rsnh_pkg::ext_coord(py_reg) - rsnh_pkg::ext_coord(light_y_reg);
        sq_x = dx * dx;
        sq_y = dy * dy;
        dsq  = sqx_reg + sqy_reg;
        // strict less-than keeps the earlier wall on a tie
        take_best = !have_hit_reg || (dsq < best_dist_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                state_next = wall_hit ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_PT;
                end
            end
            S_PT:
            begin
                state_next = S_SQX;
            end
            S_SQX:
            begin
                state_next = S_SQY;
            end
            S_SQY:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!last_reg || fin_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            have_hit_reg  <= 1'b0;
            light_x_reg   <= '0;
            light_y_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_accept)
            begin
                cnt_reg <= rsnh_pkg::CNT_W'(rsnh_pkg::DIFF_W - 1);
            end
            else if (state_reg == S_NORM)
            begin
                cnt_reg <= rsnh_pkg::CNT_W'(rsnh_pkg::MAG_W - 1);
            end
            else if ((state_reg == S_MUL) || (state_reg == S_DIV))
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fin_load)
            begin
                have_hit_reg <= 1'b0;
            end
            else if (state_reg == S_UPD)
            begin
                have_hit_reg <= 1'b1;
            end

            if (cfg_write_en)
            begin
                case (cfg_index)
                    rsnh_pkg::REG_LIGHT_X: light_x_reg <= $signed(cfg_data);
                    rsnh_pkg::REG_LIGHT_Y: light_y_reg <= $signed(cfg_data);
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ex_reg   <= ray_end_x;
            ey_reg   <= ray_end_y;
            ax_reg   <= wall_ax;
            ay_reg   <= wall_ay;
            dbx_reg  <= rsnh_pkg::ext_coord(wall_bx) - rsnh_pkg::ext_coord(wall_ax);
            dby_reg  <= rsnh_pkg::ext_coord(wall_by) - rsnh_pkg::ext_coord(wall_ay);
            last_reg <= last_wall;
        end
        if (state_reg == S_PT)
        begin
            px_reg <= px_full[rsnh_pkg::COORD_BITS-1:0];
            py_reg <= py_full[rsnh_pkg::COORD_BITS-1:0];
        end
        if (state_reg == S_SQX)
        begin
            sqx_reg <= $unsigned(sq_x);
        end
        if (state_reg == S_SQY)
        begin
            sqy_reg <= $unsigned(sq_y);
        end
        if ((state_reg == S_UPD) && take_best)
        begin
            best_dist_reg <= dsq;
            best_px_reg   <= px_reg;
            best_py_reg   <= py_reg;
        end
        if (fin_load)
        begin
            hit_found_reg <= have_hit_reg;
            end_x_reg     <= have_hit_reg ? best_px_reg : ex_reg;
            end_y_reg     <= have_hit_reg ? best_py_reg : ey_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_found = hit_found_reg;
    assign end_x     = end_x_reg;
    assign end_y     = end_y_reg;

    a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_MUL))
        else $error("accepted wall did not start the multiply");

    a_beat_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("output beat raised outside the finish step");

    a_miss_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_NORM) && !wall_hit) |=> (state_reg == S_FIN))
        else $error("missed wall entered the divide");

    a_beat_clears_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> !have_hit_reg)
        else $error("held hit not cleared with the output beat");

endmodule
